// ===== sv/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator with chunk pool.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int FRAME_BITS  = 14;
    localparam int FRAME_COUNT = 1 << FRAME_BITS;
    localparam int MAX_ORDER   = 14;
    localparam int ORD_W       = 4;
    localparam int PAGE_SHIFT  = 12;
    localparam int CHUNK_SHIFT = 9;
    localparam int CHUNK_BYTES = 1 << CHUNK_SHIFT;
    localparam int CHUNK_BITS  = PAGE_SHIFT - CHUNK_SHIFT;
    localparam int CHUNKS      = 1 << CHUNK_BITS;
    localparam int USED_W      = CHUNK_BITS + 1;
    localparam int ADDR_W      = 26;
    localparam int SIZE_W      = 27;
    localparam int PAGES_W     = SIZE_W - PAGE_SHIFT + 1;
    localparam int IN_W        = 56;
    localparam int OUT_W       = 32;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;
    localparam logic ST_DONE   = 1'b0;
    localparam logic ST_OOM    = 1'b1;

    // one frame's bookkeeping word
    typedef struct packed {
        logic                  head;
        logic                  free;
        logic [ORD_W-1:0]      order;
        logic [USED_W-1:0]     used;
        logic [CHUNKS-1:0]     map;
    } word_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic clr;
        logic scan_rd;
        logic scan_ev;
        logic split;
        logic take;
        logic free_rd;
        logic free_ev;
        logic merge_rd;
        logic merge_ev;
        logic merge_lo;
        logic fail;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic too_big;
        logic chunk_hit;
        logic exact;
        logic scan_last;
        logic found_now;
        logic split_more;
        logic fb_go;
        logic merge_top;
        logic buddy_ok;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/bpa_datapath.sv =====
// ----------------------------------------------------------------------------
// bpa_datapath
// Frame table memory, block walk, split, chunk and merge arithmetic, result.
// ----------------------------------------------------------------------------
module bpa_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bpa_pkg::cmd_t             cmd,
    output bpa_pkg::stat_t            stat,
    input  logic [bpa_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bpa_pkg::OUT_W-1:0] m_tdata
);
    import bpa_pkg::*;

    word_t mem [FRAME_COUNT];
    word_t rd_data_reg;

    logic                  rd_en;
    logic [FRAME_BITS-1:0] rd_addr;
    logic                  wr_en;
    logic [FRAME_BITS-1:0] wr_addr;
    word_t                 wr_data;

    logic [FRAME_BITS-1:0] clr_cnt_reg;
    logic [FRAME_BITS:0]   f_reg;
    logic [FRAME_BITS-1:0] best_reg, cur_p_reg, cur_p_next;
    logic [ORD_W-1:0]      best_ord_reg, best_ord_next, need_reg, cur_o_reg, cur_o_next;
    logic                  best_found_reg;
    logic                  small_reg, is_free_reg, too_big_reg;
    logic [ADDR_W-1:0]     free_addr_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    logic                  res_status_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    // request decode
    logic [SIZE_W-1:0]     in_size;
    logic [PAGES_W-1:0]    pages, pages_m1;
    logic [ORD_W:0]        in_ord;

    always_comb
    begin
        in_size  = s_tdata[SIZE_W-1:0];
        pages    = PAGES_W'(in_size[SIZE_W-1:PAGE_SHIFT]) + PAGES_W'(|in_size[PAGE_SHIFT-1:0]);
        pages_m1 = pages - PAGES_W'(1);
        in_ord   = '0;
        for (int i = 0; i < PAGES_W; i++)
        begin
            if (pages_m1[i])
                in_ord = (ORD_W+1)'(i + 1);
        end
    end

    // walk evaluation
    word_t                 w;
    logic [FRAME_BITS:0]   f_next;
    logic                  fit;

    // chunk take
    logic [CHUNK_BITS-1:0] low_bit;

    // free path
    logic [FRAME_BITS-1:0] fp;
    logic [CHUNK_BITS-1:0] fbit;
    logic                  is_chunk, bit_clear;
    word_t                 w2;
    logic                  fb_go;

    // merge
    logic [FRAME_BITS-1:0] buddy;
    logic                  buddy_ok;

    // split
    logic [ORD_W-1:0]      ord_dn;

    always_comb
    begin
        w      = rd_data_reg;
        f_next = f_reg + ((FRAME_BITS+1)'(1) << w.order);
        fit    = w.free && (w.order >= need_reg) &&
                 (!best_found_reg || (w.order < best_ord_reg));

        low_bit = '0;
        for (int i = CHUNKS - 1; i >= 0; i--)
        begin
            if (w.map[i])
                low_bit = CHUNK_BITS'(i);
        end

        fp        = free_addr_reg[ADDR_W-1:PAGE_SHIFT];
        fbit      = free_addr_reg[PAGE_SHIFT-1:CHUNK_SHIFT];
        is_chunk  = (w.used != '0);
        bit_clear = !w.map[fbit];
        w2        = w;
        if (is_chunk && bit_clear)
        begin
            w2.map[fbit] = 1'b1;
            w2.used      = w.used - USED_W'(1);
            if (w2.used == '0)
                w2.map = '0;
        end
        fb_go = (!is_chunk || (bit_clear && (w2.used == '0))) && w.head && !w.free;
        if (fb_go)
            w2.free = 1'b1;

        buddy    = cur_p_reg ^ (FRAME_BITS'(1) << cur_o_reg);
        buddy_ok = w.head && w.free && (w.order == cur_o_reg);
        ord_dn   = best_ord_reg - ORD_W'(1);
    end

    // memory ports
    always_comb
    begin
        rd_en   = cmd.scan_rd || cmd.free_rd || cmd.merge_rd;
        rd_addr = f_reg[FRAME_BITS-1:0];
        if (cmd.free_rd)
            rd_addr = fp;
        else if (cmd.merge_rd)
            rd_addr = buddy;

        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        if (cmd.clr)
        begin
            wr_en        = 1'b1;
            wr_data.free = 1'b1;
            if (clr_cnt_reg == '0)
            begin
                wr_data.head  = 1'b1;
                wr_data.order = ORD_W'(MAX_ORDER);
            end
        end
        else if (cmd.split)
        begin
            wr_en = 1'b1;
            if (best_ord_reg > need_reg)
            begin
                wr_addr       = best_reg + (FRAME_BITS'(1) << ord_dn);
                wr_data.head  = 1'b1;
                wr_data.free  = 1'b1;
                wr_data.order = ord_dn;
            end
            else
            begin
                wr_addr       = best_reg;
                wr_data.head  = 1'b1;
                wr_data.order = need_reg;
                if (small_reg)
                begin
                    wr_data.used = USED_W'(1);
                    wr_data.map  = {{(CHUNKS-1){1'b1}}, 1'b0};
                end
            end
        end
        else if (cmd.take)
        begin
            wr_en            = 1'b1;
            wr_addr          = cur_p_reg;
            wr_data          = w;
            wr_data.map[low_bit] = 1'b0;
            wr_data.used     = w.used + USED_W'(1);
        end
        else if (cmd.free_ev)
        begin
            wr_en   = 1'b1;
            wr_addr = fp;
            wr_data = w2;
        end
        else if (cmd.merge_ev)
        begin
            wr_en        = buddy_ok;
            wr_addr      = (buddy > cur_p_reg) ? buddy : cur_p_reg;
            wr_data.free = 1'b1;
        end
        else if (cmd.merge_lo)
        begin
            wr_en         = 1'b1;
            wr_addr       = cur_p_reg;
            wr_data.head  = 1'b1;
            wr_data.free  = 1'b1;
            wr_data.order = cur_o_reg + ORD_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        cur_p_next = cur_p_reg;
        cur_o_next = cur_o_reg;
        if (cmd.scan_ev)
            cur_p_next = f_reg[FRAME_BITS-1:0];
        else if (cmd.free_ev)
        begin
            cur_p_next = fp;
            cur_o_next = w.order;
        end
        else if (cmd.merge_ev && buddy_ok)
            cur_p_next = (buddy < cur_p_reg) ? buddy : cur_p_reg;
        else if (cmd.merge_lo)
            cur_o_next = cur_o_reg + ORD_W'(1);

        best_ord_next = best_ord_reg;
        if (cmd.scan_ev && fit)
            best_ord_next = w.order;
        else if (cmd.split && (best_ord_reg > need_reg))
            best_ord_next = ord_dn;
    end

    always_ff @(posedge clk)
    begin
        cur_p_reg    <= cur_p_next;
        cur_o_reg    <= cur_o_next;
        best_ord_reg <= best_ord_next;
        if (cmd.load)
        begin
            is_free_reg    <= (s_tuser == REQ_FREE);
            small_reg      <= (in_size <= SIZE_W'(CHUNK_BYTES));
            too_big_reg    <= (in_size > SIZE_W'(CHUNK_BYTES)) && (in_ord > (ORD_W+1)'(MAX_ORDER));
            need_reg       <= (in_size <= SIZE_W'(CHUNK_BYTES)) ? '0 : in_ord[ORD_W-1:0];
            free_addr_reg  <= s_tdata[SIZE_W +: ADDR_W];
            f_reg          <= '0;
            best_found_reg <= 1'b0;
            res_addr_reg   <= '0;
            res_status_reg <= ST_DONE;
        end
        else
        begin
            if (cmd.scan_ev)
            begin
                f_reg <= f_next;
                if (fit)
                begin
                    best_found_reg <= 1'b1;
                    best_reg       <= f_reg[FRAME_BITS-1:0];
                end
            end
            if (cmd.fail)
                res_status_reg <= ST_OOM;
            if (cmd.split && !(best_ord_reg > need_reg))
                res_addr_reg <= {best_reg, {PAGE_SHIFT{1'b0}}};
            if (cmd.take)
                res_addr_reg <= {cur_p_reg, low_bit, {CHUNK_SHIFT{1'b0}}};
        end
        if (cmd.finish)
            out_data_reg <= {{(OUT_W-ADDR_W-1){1'b0}}, res_status_reg, res_addr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_cnt_reg <= clr_cnt_reg + FRAME_BITS'(1);
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        stat.clr_last   = (clr_cnt_reg == '1);
        stat.is_free    = is_free_reg;
        stat.too_big    = too_big_reg;
        stat.chunk_hit  = small_reg && (w.map != '0);
        stat.exact      = !small_reg && fit && (w.order == need_reg);
        stat.scan_last  = f_next[FRAME_BITS];
        stat.found_now  = best_found_reg || fit;
        stat.split_more = (best_ord_reg > need_reg);
        stat.fb_go      = fb_go;
        stat.merge_top  = (cur_o_reg >= ORD_W'(MAX_ORDER));
        stat.buddy_ok   = buddy_ok;
        stat.out_free   = !out_valid_reg || m_tready;
    end

endmodule

// ===== sv/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clearing, block walk, split, chunk take, free and merge.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  bpa_pkg::stat_t stat,
    output bpa_pkg::cmd_t  cmd
);
    import bpa_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DISPATCH = 13'b0000000000100,
        S_SCAN_RD  = 13'b0000000001000,
        S_SCAN_EV  = 13'b0000000010000,
        S_SPLIT    = 13'b0000000100000,
        S_TAKE     = 13'b0000001000000,
        S_FREE_RD  = 13'b0000010000000,
        S_FREE_EV  = 13'b0000100000000,
        S_MERGE_RD = 13'b0001000000000,
        S_MERGE_EV = 13'b0010000000000,
        S_MERGE_LO = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_free)
                    state_next = S_FREE_RD;
                else if (stat.too_big)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.scan_ev = 1'b1;
                if (stat.chunk_hit)
                    state_next = S_TAKE;
                else if (stat.exact)
                    state_next = S_SPLIT;
                else if (stat.scan_last)
                begin
                    if (stat.found_now)
                        state_next = S_SPLIT;
                    else
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                    state_next = S_SCAN_RD;
            end
            S_SPLIT:
            begin
                cmd.split = 1'b1;
                if (!stat.split_more)
                    state_next = S_DONE;
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_DONE;
            end
            S_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
                state_next  = S_FREE_EV;
            end
            S_FREE_EV:
            begin
                cmd.free_ev = 1'b1;
                state_next  = stat.fb_go ? S_MERGE_RD : S_DONE;
            end
            S_MERGE_RD:
            begin
                if (stat.merge_top)
                    state_next = S_DONE;
                else
                begin
                    cmd.merge_rd = 1'b1;
                    state_next   = S_MERGE_EV;
                end
            end
            S_MERGE_EV:
            begin
                cmd.merge_ev = 1'b1;
                state_next   = stat.buddy_ok ? S_MERGE_LO : S_DONE;
            end
            S_MERGE_LO:
            begin
                cmd.merge_lo = 1'b1;
                state_next   = S_MERGE_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/buddy_page_allocator_with_chunk_pool.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_with_chunk_pool
// Binary buddy allocator over 4 KiB frames with a 512-byte chunk pool.
// ----------------------------------------------------------------------------
// channel  dir  signals                    contents
// s_*      in   tvalid tready tdata tuser  request: size, free address, kind
// m_*      out  tvalid tready tdata        result: address, status
//
// One request at a time. An allocate reads and evaluates each block visited on the
// block list walk, then writes one split per step and marks the grant; a chunk take
// updates the chunk map instead. A free reads and updates its frame; if that releases
// the block, it checks and merges buddies level by level until the merge walk ends.
// Each request is also accepted, dispatched and finished. After reset the frame table
// is cleared before s_tready rises. A result held on m_* stalls only the finish step.
// ----------------------------------------------------------------------------
module buddy_page_allocator_with_chunk_pool (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bpa_pkg::IN_W-1:0]  s_tdata,  // size_bytes[26:0], free_address[52:27]
    input  logic                      s_tuser,  // req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bpa_pkg::OUT_W-1:0] m_tdata   // address[25:0], status[26]
);
    import bpa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = cmd.ready;

endmodule

// ===== tb/tb_buddy_page_allocator_with_chunk_pool.sv =====
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator_with_chunk_pool
// Self-checking bench for the buddy page allocator with chunk pool: a
// directed pass over the corner cases, then random allocate/free traffic
// built from the addresses actually granted. Every accepted request is run
// through a behavioral model of the allocator and the predicted grant is
// checked against the result stream in order.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator_with_chunk_pool;
    import bpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] faddr;
    } req_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              status;
    } grant_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    // frame table of the model
    logic [ORD_W-1:0]    fr_order [FRAME_COUNT];
    logic                fr_head  [FRAME_COUNT];
    logic                fr_free  [FRAME_COUNT];
    logic [USED_W-1:0]   fr_used  [FRAME_COUNT];
    logic [CHUNKS-1:0]   fr_map   [FRAME_COUNT];

    req_t                pending_reqs[$];
    grant_t              grants_due[$];
    logic [ADDR_W-1:0]   live_addrs[$];
    logic [ADDR_W-1:0]   last_freed;
    req_t                cur_req;
    int                  send_idle = 10;
    int                  recv_stall = 77;
    int                  mismatches = 0;

    buddy_page_allocator_with_chunk_pool dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void reset_frames();
        for (int f = 0; f < FRAME_COUNT; f++)
        begin
            fr_order[f] = '0;
            fr_head[f]  = 1'b0;
            fr_free[f]  = 1'b1;
            fr_used[f]  = '0;
            fr_map[f]   = '0;
        end
        fr_head[0]  = 1'b1;
        fr_order[0] = ORD_W'(MAX_ORDER);
    endfunction

    // Smallest-order, lowest-address free block; heads tile the store, so
    // walking block to block visits every head.
    function automatic int take_block(input int need);
        int best;
        int best_ord;
        int f;
        int up;
        best = -1;
        best_ord = 0;
        f = 0;
        if (need > MAX_ORDER)
            return -1;
        while (f < FRAME_COUNT)
        begin
            if (fr_head[f] && fr_free[f] && fr_order[f] >= need &&
                (best < 0 || fr_order[f] < best_ord))
            begin
                best = f;
                best_ord = fr_order[f];
            end
            f += 1 << fr_order[f];
        end
        if (best < 0)
            return -1;
        while (best_ord > need)
        begin
            best_ord--;
            up = best + (1 << best_ord);
            fr_head[up]  = 1'b1;
            fr_free[up]  = 1'b1;
            fr_order[up] = ORD_W'(best_ord);
            fr_order[best] = ORD_W'(best_ord);
        end
        fr_free[best] = 1'b0;
        return best;
    endfunction

    function automatic void release_block(input int p);
        int o;
        int buddy;
        int lo;
        int hi;
        if (!fr_head[p] || fr_free[p])
            return;
        fr_free[p] = 1'b1;
        forever
        begin
            o = fr_order[p];
            if (o >= MAX_ORDER)
                break;
            buddy = p ^ (1 << o);
            if (buddy + (1 << o) > FRAME_COUNT)
                break;
            if (!(fr_head[buddy] && fr_free[buddy] && fr_order[buddy] == o))
                break;
            lo = buddy < p ? buddy : p;
            hi = buddy < p ? p : buddy;
            fr_head[hi]  = 1'b0;
            fr_free[hi]  = 1'b1;
            fr_order[hi] = '0;
            fr_order[lo] = ORD_W'(o + 1);
            fr_free[lo]  = 1'b1;
            p = lo;
        end
    endfunction

    function automatic grant_t serve_request(input req_t r);
        grant_t g;
        longint pages;
        int ord;
        int f;
        int page;
        int bit_i;
        g.addr = '0;
        g.status = ST_DONE;
        if (r.kind == REQ_ALLOC)
        begin
            if (r.size > CHUNK_BYTES)
            begin
                pages = (longint'(r.size) + 4095) >> PAGE_SHIFT;
                ord = 0;
                while ((64'd1 << ord) < pages && ord < 40)
                    ord++;
                f = take_block(ord);
                if (f < 0)
                    g.status = ST_OOM;
                else
                    g.addr = ADDR_W'(f << PAGE_SHIFT);
            end
            else
            begin
                page = -1;
                f = 0;
                while (f < FRAME_COUNT)
                begin
                    if (fr_map[f] != 0)
                    begin
                        page = f;
                        break;
                    end
                    f += 1 << fr_order[f];
                end
                if (page < 0)
                begin
                    page = take_block(0);
                    if (page >= 0)
                    begin
                        fr_map[page]  = '1;
                        fr_used[page] = '0;
                    end
                end
                if (page < 0)
                    g.status = ST_OOM;
                else
                begin
                    bit_i = 0;
                    while (!fr_map[page][bit_i])
                        bit_i++;
                    fr_map[page][bit_i] = 1'b0;
                    fr_used[page]++;
                    g.addr = ADDR_W'((page << PAGE_SHIFT) + bit_i * CHUNK_BYTES);
                end
            end
        end
        else
        begin
            page = int'(r.faddr >> PAGE_SHIFT);
            if (fr_used[page] != 0)
            begin
                bit_i = int'(r.faddr[PAGE_SHIFT-1:CHUNK_SHIFT]);
                if (!fr_map[page][bit_i])
                begin
                    fr_map[page][bit_i] = 1'b1;
                    fr_used[page]--;
                    if (fr_used[page] == 0)
                    begin
                        fr_map[page] = '0;
                        release_block(page);
                    end
                end
            end
            else
                release_block(page);
        end
        return g;
    endfunction

    // driver: model runs on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                grant_t g;
                g = serve_request(cur_req);
                grants_due.push_back(g);
                if (cur_req.kind == REQ_ALLOC && g.status == ST_DONE)
                    live_addrs.push_back(g.addr);
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(IN_W-SIZE_W-ADDR_W){1'b0}}, cur_req.faddr, cur_req.size};
                s_tuser  <= cur_req.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= $urandom_range(99) >= recv_stall;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grants_due.size() == 0)
                report("unexpected result", m_tdata, '0);
            else
            begin
                grant_t g;
                g = grants_due.pop_front();
                if (m_tdata[ADDR_W-1:0] !== g.addr)
                    report("address", 32'(m_tdata[ADDR_W-1:0]), 32'(g.addr));
                if (m_tdata[ADDR_W] !== g.status)
                    report("status", 32'(m_tdata[ADDR_W]), 32'(g.status));
            end
        end
    end

    task automatic push_req(input logic kind, input logic [SIZE_W-1:0] size,
                            input logic [ADDR_W-1:0] faddr);
        req_t r;
        r.kind = kind;
        r.size = size;
        r.faddr = faddr;
        pending_reqs.push_back(r);
    endtask

    // checked away from the rising edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || grants_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic gen_random();
        int r;
        int idx;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(99);
        if (live_addrs.size() > 40 && r >= 20)
            r = 70;
        if (r < 6)
            push_req(REQ_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom));
        else if (r < 11)
            push_req(REQ_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
        else if (r < 14)
            push_req(REQ_FREE, SIZE_W'($urandom), last_freed);
        else if (r < 60 || live_addrs.size() == 0)
        begin
            r = $urandom_range(99);
            if (r < 50)
                push_req(REQ_ALLOC, SIZE_W'($urandom_range(CHUNK_BYTES)), ADDR_W'($urandom));
            else if (r < 92)
                push_req(REQ_ALLOC, SIZE_W'($urandom_range(16 * 4096, CHUNK_BYTES + 1)),
                         ADDR_W'($urandom));
            else
                push_req(REQ_ALLOC, SIZE_W'($urandom_range(1 << 26, 1 << 21)),
                         ADDR_W'($urandom));
        end
        else
        begin
            idx = $urandom_range(live_addrs.size() - 1);
            a = live_addrs[idx];
            live_addrs.delete(idx);
            last_freed = a;
            // an offset below the chunk size still names the same chunk or frame
            if ($urandom_range(3) == 0)
                a = a + ADDR_W'($urandom_range(CHUNK_BYTES - 1));
            push_req(REQ_FREE, SIZE_W'($urandom), a);
        end
    endtask

    initial
    begin
        reset_frames();
        last_freed = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // whole store, small requests fail, the store is freed, then an oversize request
        push_req(REQ_ALLOC, 27'd67108864, 26'h3FFFFFF);
        push_req(REQ_ALLOC, 27'd1, '0);
        push_req(REQ_ALLOC, 27'd8192, '0);
        push_req(REQ_FREE, 27'h7FFFFFF, '0);
        push_req(REQ_ALLOC, 27'd67108865, '0);
        // chunk pool and small blocks
        push_req(REQ_ALLOC, 27'd0, '0);
        push_req(REQ_ALLOC, 27'd1, '0);
        push_req(REQ_ALLOC, 27'd512, '0);
        push_req(REQ_ALLOC, 27'd513, '0);
        push_req(REQ_ALLOC, 27'd4097, '0);
        push_req(REQ_FREE, '0, 26'h2123);      // offset inside a block frame
        push_req(REQ_FREE, '0, 26'h205);       // chunk picked by offset
        push_req(REQ_FREE, '0, 26'h200);       // chunk already free
        push_req(REQ_FREE, '0, 26'h5000);      // not a block head
        push_req(REQ_FREE, '0, 26'h1000);
        push_req(REQ_FREE, '0, 26'h0);
        push_req(REQ_FREE, '0, 26'h400);       // last chunk returns the page
        push_req(REQ_ALLOC, 27'd67108863, '0);
        push_req(REQ_FREE, '0, 26'h3FFFFFF);
        push_req(REQ_FREE, '0, 26'h0);
        push_req(REQ_FREE, '0, 26'h0);         // already free
        wait_drained();
        live_addrs.delete();

        for (int n = 0; n < 1600; n++)
        begin
            if (n == 533)
            begin
                send_idle = 77;
                recv_stall = 10;
            end
            else if (n == 1066)
            begin
                send_idle = 0;
                recv_stall = 0;
            end
            if (n == 800 || n == 1300)
                wait_drained();
            while (pending_reqs.size() != 0)
                @(posedge clk);
            gen_random();
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

endmodule
